### rtl/dvrt_pkg.sv
// Shared types and codes for the distance-vector route table.
// No dependencies; imported by the controller, the datapath and the top level.
package dvrt_pkg;

	// Action codes carried on the request channel
	localparam logic ACT_MERGE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// Merge outcome codes reported on the response channel
	typedef enum logic [1:0] {
		OUTCOME_UNCHANGED = 2'd0,
		OUTCOME_ADDED     = 2'd1,
		OUTCOME_IMPROVED  = 2'd2,
		OUTCOME_DROPPED   = 2'd3
	} outcome_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;     // latch the request fields, restart the scan
		logic scan;        // step the lookup through the stored routes
		logic slot_rd;     // read the slot named by a read request
		logic fin_slot;    // present a slot read result
		logic fin_append;  // append the route (or drop it when full)
		logic fin_update;  // replace a hit route if the metric improves
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic req_action;  // action field of the request now offered
		logic ptr_done;    // scan pointer has reached the route count
		logic hit;         // entry in the read stage matches the destination
		logic out_free;    // response register can take a new transaction
	} ctrl_status_t;

endpackage

### rtl/distance_vector_route_table.sv
// Distance-vector route table. A merge scans the stored routes in order and
// ends the lookup at the first hit or at the end of the stored routes; a new
// request is taken only once the previous transaction has finished. The lookup reads one stored
// route per cycle through the single read port.
// Reset (arst_n, asynchronous) empties the table at once: the fill count
// is cleared, no memory clearing pass is needed.
module distance_vector_route_table #(
	parameter int TABLE_DEPTH  = 64,
	parameter int METRIC_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        action,
	input  logic [7:0]  destination,
	input  logic [15:0] advertised_metric,
	input  logic [7:0]  from_router,
	input  logic [7:0]  link_cost,
	input  logic        last_of_table,
	input  logic [5:0]  slot_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  outcome,
	output logic        table_changed,
	output logic        slot_valid,
	output logic [7:0]  out_destination,
	output logic [7:0]  out_next_hop,
	output logic [15:0] out_metric
);
	import dvrt_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	dvrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dvrt_datapath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.METRIC_WIDTH (METRIC_WIDTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.action            (action),
		.destination       (destination),
		.advertised_metric (advertised_metric),
		.from_router       (from_router),
		.link_cost         (link_cost),
		.last_of_table     (last_of_table),
		.slot_index        (slot_index),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.outcome           (outcome),
		.table_changed     (table_changed),
		.slot_valid        (slot_valid),
		.out_destination   (out_destination),
		.out_next_hop      (out_next_hop),
		.out_metric        (out_metric)
	);

endmodule

### rtl/dvrt_ctrl.sv
// Sequencer for the route table: accept, lookup, commit and respond.
// Depends on dvrt_pkg for the command and status structs.
module dvrt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  dvrt_pkg::ctrl_status_t status,
	output dvrt_pkg::ctrl_cmd_t    cmd
);
	import dvrt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT_RD,
		ST_SLOT_OUT,
		ST_LOOKUP,
		ST_APPEND,
		ST_UPDATE
	} state_t;

	state_t state_q;

	// Requests are taken only between transactions
	assign req_stall = (state_q != ST_IDLE);

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.capture    = req_valid;
			ST_SLOT_RD:  cmd.slot_rd    = 1'b1;
			ST_SLOT_OUT: cmd.fin_slot   = status.out_free;
			ST_LOOKUP:   cmd.scan       = 1'b1;
			ST_APPEND:   cmd.fin_append = status.out_free;
			ST_UPDATE:   cmd.fin_update = status.out_free;
			default:     cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= (status.req_action == ACT_READ) ? ST_SLOT_RD : ST_LOOKUP;
					end
				end
				ST_SLOT_RD: begin
					state_q <= ST_SLOT_OUT;
				end
				ST_LOOKUP: begin
					// a hit wins over the end of the scan
					priority if (status.hit) begin
						state_q <= ST_UPDATE;
					end else if (status.ptr_done) begin
						state_q <= ST_APPEND;
					end
				end
				ST_SLOT_OUT, ST_APPEND, ST_UPDATE: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/dvrt_datapath.sv
// Route storage, lookup pipeline, metric arithmetic and response register.
// Depends on dvrt_pkg; driven by dvrt_ctrl through the command struct.
module dvrt_datapath #(
	parameter int TABLE_DEPTH  = 64,
	parameter int METRIC_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dvrt_pkg::ctrl_cmd_t    cmd,
	output dvrt_pkg::ctrl_status_t status,
	input  logic                   action,
	input  logic [7:0]             destination,
	input  logic [15:0]            advertised_metric,
	input  logic [7:0]             from_router,
	input  logic [7:0]             link_cost,
	input  logic                   last_of_table,
	input  logic [5:0]             slot_index,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [1:0]             outcome,
	output logic                   table_changed,
	output logic                   slot_valid,
	output logic [7:0]             out_destination,
	output logic [7:0]             out_next_hop,
	output logic [15:0]            out_metric
);
	import dvrt_pkg::*;

	localparam int MW = METRIC_WIDTH;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (CW > 6) ? CW : 6;
	localparam int EW = 16 + MW;
	localparam int XW = MW + 17;
	localparam logic [MW-1:0] METRIC_MAX = '1;
	localparam logic [CW-1:0] DEPTH_C    = CW'(TABLE_DEPTH);

	// Route entry: {destination, next hop, metric}
	logic [EW-1:0] mem [TABLE_DEPTH];

	logic [7:0]    dest_q;
	logic [7:0]    from_q;
	logic [MW-1:0] cand_q;
	logic          last_q;
	logic [5:0]    slot_q;

	logic [CW-1:0] ptr_q;
	logic [CW-1:0] count_q;
	logic          pending_q;

	logic [EW-1:0] rd_data_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          rv_s1;
	logic          slot_ok_s1;

	logic          out_valid_q;
	outcome_t      outcome_q;
	logic          changed_q;
	logic          svalid_q;
	logic [7:0]    odest_q;
	logic [7:0]    onext_q;
	logic [15:0]   ometric_q;

	// Candidate metric: clamp the advertisement, add the link cost, saturate
	logic [XW-1:0] adv_x, max_x, adv_c, sum_x;
	logic [MW-1:0] cand_d;
	always_comb begin
		adv_x  = XW'(advertised_metric);
		max_x  = XW'(METRIC_MAX);
		adv_c  = (adv_x > max_x) ? max_x : adv_x;
		sum_x  = adv_c + XW'(link_cost);
		cand_d = (sum_x > max_x) ? METRIC_MAX : sum_x[MW-1:0];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dest_q   <= destination;
			from_q   <= from_router;
			cand_q   <= cand_d;
			last_q   <= last_of_table;
			slot_q   <= slot_index;
		end
	end

	// Lookup and slot read share the one read port
	logic [SW-1:0] slot_ext;
	logic          slot_ok;
	logic          full;
	logic          hit;
	logic          scan_rd;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [MW-1:0] rd_metric;
	logic          improve;

	assign slot_ext  = SW'(slot_q);
	assign slot_ok   = (slot_ext < SW'(count_q));
	assign full      = (count_q == DEPTH_C);
	assign rd_metric = rd_data_s1[MW-1:0];
	assign hit       = rv_s1 && (rd_data_s1[EW-1:EW-8] == dest_q);
	assign improve   = (cand_q < rd_metric);
	assign scan_rd   = cmd.scan && (ptr_q != count_q) && !hit;
	assign rd_en     = scan_rd || (cmd.slot_rd && slot_ok);
	assign rd_addr   = cmd.scan ? ptr_q[AW-1:0] : slot_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1      <= 1'b0;
			slot_ok_s1 <= 1'b0;
			ptr_q      <= '0;
		end else begin
			rv_s1 <= scan_rd;
			if (cmd.slot_rd) begin
				slot_ok_s1 <= slot_ok;
			end
			if (cmd.capture) begin
				ptr_q <= '0;
			end else if (scan_rd) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Table write: append at the fill count, or replace the hit entry
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	assign wr_en   = (cmd.fin_append && !full) || (cmd.fin_update && improve);
	assign wr_addr = cmd.fin_append ? count_q[AW-1:0] : rd_addr_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {dest_q, from_q, cand_q};
		end
	end

	// Route count and change tracking over one advertisement
	logic merge_fin;
	logic pend_new;
	assign merge_fin = cmd.fin_append || cmd.fin_update;
	assign pend_new  = pending_q || wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= 1'b0;
		end else begin
			if (cmd.fin_append && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (merge_fin) begin
				pending_q <= last_q ? 1'b0 : pend_new;
			end
		end
	end

	// Response register
	logic [MW-1:0] metric_inc;
	logic [MW+15:0] metric_ext;
	assign metric_inc = (rd_metric == METRIC_MAX) ? METRIC_MAX : rd_metric + 1'b1;
	assign metric_ext = {16'b0, metric_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_slot || merge_fin) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_slot) begin
			outcome_q <= OUTCOME_UNCHANGED;
			changed_q <= 1'b0;
			svalid_q  <= slot_ok_s1;
			odest_q   <= slot_ok_s1 ? rd_data_s1[EW-1:EW-8] : 8'd0;
			onext_q   <= slot_ok_s1 ? rd_data_s1[EW-9:MW] : 8'd0;
			ometric_q <= slot_ok_s1 ? metric_ext[15:0] : 16'd0;
		end else if (merge_fin) begin
			priority if (cmd.fin_append) begin
				outcome_q <= full ? OUTCOME_DROPPED : OUTCOME_ADDED;
			end else if (improve) begin
				outcome_q <= OUTCOME_IMPROVED;
			end else begin
				outcome_q <= OUTCOME_UNCHANGED;
			end
			changed_q <= last_q && pend_new;
			svalid_q  <= 1'b0;
			odest_q   <= 8'd0;
			onext_q   <= 8'd0;
			ometric_q <= 16'd0;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign outcome         = outcome_q;
	assign table_changed   = changed_q;
	assign slot_valid      = svalid_q;
	assign out_destination = odest_q;
	assign out_next_hop    = onext_q;
	assign out_metric      = ometric_q;

	// Status to the controller
	assign status.req_action = action;
	assign status.ptr_done   = (ptr_q == count_q);
	assign status.hit        = hit;
	assign status.out_free   = !out_valid_q || !rsp_stall;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("route count exceeds table depth");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin_append && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not advance the route count");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(merge_fin && last_q) |=> !pending_q)
		else $error("change flag survived the end of an advertisement");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_rd |-> (ptr_q < count_q))
		else $error("lookup read beyond the stored routes");

endmodule
